### src/sorted_event_queue_assert.svh
// Assertion macros shared by the sorted event queue modules.
`ifndef SORTED_EVENT_QUEUE_ASSERT_SVH
`define SORTED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SEVQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SEVQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sevq_pkg.sv
// Types and constants shared by the sorted event queue modules.
package sevq_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Action codes
    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_EXTRACT  = 1'b1;

    // Reported next time when the queue holds nothing
    localparam logic signed [31:0] NO_TIME = -32'sd1;

    // Input item
    typedef struct packed {
        logic        action;
        logic [30:0] event_time;
        logic [1:0]  event_kind;
        logic        has_terminal;
        logic [7:0]  terminal_ref;
        logic        has_record;
        logic [7:0]  record_ref;
        logic [15:0] record_version;
    } item_t;

    // Result item
    typedef struct packed {
        status_t            status;
        logic [30:0]        out_time;
        logic [1:0]         out_kind;
        logic               out_has_terminal;
        logic [7:0]         out_terminal_ref;
        logic               out_has_record;
        logic [7:0]         out_record_ref;
        logic [15:0]        out_record_version;
        logic signed [31:0] next_time;
        logic [6:0]         pending_count;
    } result_t;

    // One stored event
    typedef struct packed {
        logic [30:0] event_time;
        logic [1:0]  event_kind;
        logic        has_terminal;
        logic [7:0]  terminal_ref;
        logic        has_record;
        logic [7:0]  record_ref;
        logic [15:0] record_version;
    } entry_t;

    // Which logical slot the memory read addresses
    typedef enum logic [1:0] {
        RD_SCAN  = 2'd0,
        RD_HEAD0 = 2'd1,
        RD_HEAD1 = 2'd2
    } rd_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_INS_RD  = 3'd1,
        S_INS_CMP = 3'd2,
        S_EXT_RD0 = 3'd3,
        S_EXT_RD1 = 3'd4,
        S_EXT_FIN = 3'd5,
        S_REPORT  = 3'd6
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        status_t load_status;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    wr_new;
        logic    dec_k;
        logic    ins_commit;
        logic    ext_capture;
        logic    ext_commit;
        logic    emit;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic k_zero;
        logic rd_gt;
    } dp_stat_t;

endpackage

### src/sorted_event_queue.sv
// Top level of the sorted event queue: controller plus datapath.
//
// Usage
//   Input channel: drive item and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. action 0 schedules an
//   event, action 1 extracts the earliest one.
//   Result channel: result is valid for the single cycle that done is high.
//   Every input transfer yields exactly one result; the receiver cannot stall.
//   Sequence after the transfer:
//     schedule when full, or extract when empty: straight to the report
//     schedule: read and compare each later stored event, shifting it up one
//       slot, until an earlier or equal event or the head is reached
//     extract: read the head and second slots, then commit and report
//   Throughput: one item at a time; busy stays high until the result is
//   registered. The insertion scan moves one stored event at a time
//   through the event memory (registered read, then compare/write).
//   Events live in a circular memory, so extract is constant time.
//   Reset: asynchronous, active low; the queue comes up empty, no clearing
//   pass is needed.
module sorted_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sevq_pkg::item_t   item,
    output logic              done,
    output sevq_pkg::result_t result
);

    sevq_pkg::ctrl_cmd_t cmd;
    sevq_pkg::dp_stat_t  stat;

    // Sequencer
    sevq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Storage and result formation
    sevq_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

### src/sevq_datapath.sv
// Datapath: circular event memory, head and count registers, result register.
module sevq_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sevq_pkg::item_t     item,
    input  sevq_pkg::ctrl_cmd_t cmd,
    output sevq_pkg::dp_stat_t  stat,
    output sevq_pkg::result_t   result,
    output logic                done
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Logical slot to physical address, wrapping past the end of the memory
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] slot);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(slot);
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    sevq_pkg::entry_t mem [DEPTH];

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     k_reg, k_next;
    sevq_pkg::entry_t  item_reg, item_next;
    sevq_pkg::status_t stat_reg, stat_next;
    sevq_pkg::entry_t  ext_reg, ext_next;
    logic [30:0]       head_time_reg, head_time_next;
    sevq_pkg::entry_t  rd_reg;
    sevq_pkg::result_t result_reg, result_next;
    logic              done_reg, done_next;

    sevq_pkg::entry_t  new_entry;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    sevq_pkg::entry_t  wr_data;
    logic              wr_en;

    // Incoming event with absent references cleared
    always_comb
    begin
        new_entry.event_time     = item.event_time;
        new_entry.event_kind     = item.event_kind;
        new_entry.has_terminal   = item.has_terminal;
        new_entry.terminal_ref   = item.has_terminal ? item.terminal_ref : 8'd0;
        new_entry.has_record     = item.has_record;
        new_entry.record_ref     = item.has_record ? item.record_ref : 8'd0;
        new_entry.record_version = item.has_record ? item.record_version : 16'd0;
    end

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            sevq_pkg::RD_SCAN:  rd_addr = phys(head_reg, k_reg - 1'b1);
            sevq_pkg::RD_HEAD0: rd_addr = head_reg;
            sevq_pkg::RD_HEAD1: rd_addr = phys(head_reg, CW'(1));
            default:            rd_addr = head_reg;
        endcase
    end

    // Write port: shift an entry up one slot or drop the new event in
    assign wr_addr = phys(head_reg, k_reg);
    assign wr_en   = cmd.wr_shift | cmd.wr_new;
    assign wr_data = cmd.wr_new ? item_reg : rd_reg;

    // Event memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Register updates
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        item_next      = item_reg;
        stat_next      = stat_reg;
        ext_next       = ext_reg;
        head_time_next = head_time_reg;
        if (cmd.load)
        begin
            k_next    = count_reg;
            item_next = new_entry;
            stat_next = cmd.load_status;
            ext_next  = '0;
        end
        if (cmd.dec_k)
        begin
            k_next = k_reg - 1'b1;
        end
        if (cmd.ins_commit)
        begin
            count_next = count_reg + 1'b1;
            if (k_reg == '0)
            begin
                head_time_next = item_reg.event_time;
            end
        end
        if (cmd.ext_capture)
        begin
            ext_next = rd_reg;
        end
        // rd_reg holds the second slot here, which becomes the new head
        if (cmd.ext_commit)
        begin
            head_next  = phys(head_reg, CW'(1));
            count_next = count_reg - 1'b1;
            if (count_reg > CW'(1))
            begin
                head_time_next = rd_reg.event_time;
            end
        end
    end

    // Result assembly from the settled state
    always_comb
    begin
        result_next.status             = stat_reg;
        result_next.out_time           = ext_reg.event_time;
        result_next.out_kind           = ext_reg.event_kind;
        result_next.out_has_terminal   = ext_reg.has_terminal;
        result_next.out_terminal_ref   = ext_reg.terminal_ref;
        result_next.out_has_record     = ext_reg.has_record;
        result_next.out_record_ref     = ext_reg.record_ref;
        result_next.out_record_version = ext_reg.record_version;
        result_next.next_time          = (count_reg == '0) ? sevq_pkg::NO_TIME
                                                           : signed'({1'b0, head_time_reg});
        result_next.pending_count      = 7'(count_reg);
        done_next                      = cmd.emit;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        item_reg      <= item_next;
        stat_reg      <= stat_next;
        ext_reg       <= ext_next;
        head_time_reg <= head_time_next;
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.full   = (count_reg == CW'(DEPTH));
    assign stat.empty  = (count_reg == '0);
    assign stat.k_zero = (k_reg == '0);
    assign stat.rd_gt  = (rd_reg.event_time > item_reg.event_time);
    assign result      = result_reg;
    assign done        = done_reg;

`include "sorted_event_queue_assert.svh"

    `SEVQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "event count above depth")
    `SEVQ_ASSERT_NEXT(a_insert_count, cmd.wr_new, count_reg == $past(count_reg) + 1'b1, "insert lost count")

endmodule

### src/sevq_ctrl.sv
// Controller: sequences the insertion scan and the extract reads.
module sevq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  sevq_pkg::dp_stat_t  stat,
    output sevq_pkg::ctrl_cmd_t cmd,
    output logic                busy
);

    sevq_pkg::state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sevq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (action == sevq_pkg::ACT_SCHEDULE && !stat.full)
                    begin
                        state_next = sevq_pkg::S_INS_RD;
                    end
                    else if (action == sevq_pkg::ACT_EXTRACT && !stat.empty)
                    begin
                        state_next = sevq_pkg::S_EXT_RD0;
                    end
                    else
                    begin
                        state_next = sevq_pkg::S_REPORT;
                    end
                end
            end
            sevq_pkg::S_INS_RD:
            begin
                state_next = stat.k_zero ? sevq_pkg::S_REPORT : sevq_pkg::S_INS_CMP;
            end
            sevq_pkg::S_INS_CMP:
            begin
                state_next = stat.rd_gt ? sevq_pkg::S_INS_RD : sevq_pkg::S_REPORT;
            end
            sevq_pkg::S_EXT_RD0: state_next = sevq_pkg::S_EXT_RD1;
            sevq_pkg::S_EXT_RD1: state_next = sevq_pkg::S_EXT_FIN;
            sevq_pkg::S_EXT_FIN: state_next = sevq_pkg::S_REPORT;
            sevq_pkg::S_REPORT:  state_next = sevq_pkg::S_IDLE;
            default:             state_next = sevq_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        cmd.load_status = sevq_pkg::ST_DONE;
        cmd.rd_sel      = sevq_pkg::RD_SCAN;
        case (state_reg)
            sevq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (action == sevq_pkg::ACT_SCHEDULE && stat.full)
                    begin
                        cmd.load_status = sevq_pkg::ST_FULL;
                    end
                    else if (action == sevq_pkg::ACT_EXTRACT && stat.empty)
                    begin
                        cmd.load_status = sevq_pkg::ST_EMPTY;
                    end
                end
            end
            sevq_pkg::S_INS_RD:
            begin
                if (stat.k_zero)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.ins_commit = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sevq_pkg::RD_SCAN;
                end
            end
            // Later event moves up one slot, else the new one lands here
            sevq_pkg::S_INS_CMP:
            begin
                if (stat.rd_gt)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.dec_k    = 1'b1;
                end
                else
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.ins_commit = 1'b1;
                end
            end
            sevq_pkg::S_EXT_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sevq_pkg::RD_HEAD0;
            end
            sevq_pkg::S_EXT_RD1:
            begin
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = sevq_pkg::RD_HEAD1;
                cmd.ext_capture = 1'b1;
            end
            sevq_pkg::S_EXT_FIN: cmd.ext_commit = 1'b1;
            sevq_pkg::S_REPORT:  cmd.emit = 1'b1;
            default:             cmd.emit = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sevq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != sevq_pkg::S_IDLE);

`include "sorted_event_queue_assert.svh"

    `SEVQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
    `SEVQ_ASSERT_SAME(a_cmp_after_rd, state_reg == sevq_pkg::S_INS_CMP, $past(state_reg) == sevq_pkg::S_INS_RD, "compare without read")

endmodule

### test/tb_sorted_event_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_event_queue: scheduled events are checked against a sorted calendar model.
module tb_sorted_event_queue;
    import sevq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
    localparam int PRINT_CAP    = 50;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    item_t   item;
    result_t result;

    // Calendar model: events sorted by time, ties kept in arrival order
    entry_t  calendar[$];
    // Results still owed by the block, oldest first
    result_t due_results[$];

    int unsigned error_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned full_seen    = 0;
    int unsigned empty_seen   = 0;
    int unsigned peak_fill    = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          idle_off     = 1'b0;

    sorted_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one item to the calendar model and return the result it owes
    function automatic result_t calendar_step(item_t it);
        result_t r;
        entry_t  ev;
        int      pos;
        r        = '0;
        r.status = ST_DONE;
        if (it.action == ACT_SCHEDULE)
        begin
            if (calendar.size() >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                ev.event_time     = it.event_time;
                ev.event_kind     = it.event_kind;
                ev.has_terminal   = it.has_terminal;
                ev.terminal_ref   = it.has_terminal ? it.terminal_ref : 8'd0;
                ev.has_record     = it.has_record;
                ev.record_ref     = it.has_record ? it.record_ref : 8'd0;
                ev.record_version = it.has_record ? it.record_version : 16'd0;
                pos = 0;
                while (pos < calendar.size() && calendar[pos].event_time <= it.event_time)
                    pos++;
                calendar.insert(pos, ev);
            end
        end
        else
        begin
            if (calendar.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                ev                   = calendar.pop_front();
                r.out_time           = ev.event_time;
                r.out_kind           = ev.event_kind;
                r.out_has_terminal   = ev.has_terminal;
                r.out_terminal_ref   = ev.terminal_ref;
                r.out_has_record     = ev.has_record;
                r.out_record_ref     = ev.record_ref;
                r.out_record_version = ev.record_version;
            end
        end
        if (calendar.size() > 0)
            r.next_time = signed'({1'b0, calendar[0].event_time});
        else
            r.next_time = NO_TIME;
        r.pending_count = 7'(calendar.size());
        return r;
    endfunction

    // Fully random item; used as noise while start is low and as a base for real items
    function automatic item_t noise_item();
        item_t it;
        it.action         = 1'($urandom);
        it.event_time     = 31'($urandom);
        it.event_kind     = 2'($urandom);
        it.has_terminal   = 1'($urandom);
        it.terminal_ref   = 8'($urandom);
        it.has_record     = 1'($urandom);
        it.record_ref     = 8'($urandom);
        it.record_version = 16'($urandom);
        return it;
    endfunction

    function automatic item_t schedule_item(logic [30:0] t);
        item_t it;
        it            = noise_item();
        it.action     = ACT_SCHEDULE;
        it.event_time = t;
        return it;
    endfunction

    function automatic item_t extract_item();
        item_t it;
        it        = noise_item();
        it.action = ACT_EXTRACT;
        return it;
    endfunction

    function automatic item_t event_item(logic [30:0] t, logic [1:0] kind, logic ht,
                                         logic [7:0] tr, logic hr, logic [7:0] rr,
                                         logic [15:0] ver);
        item_t it;
        it.action         = ACT_SCHEDULE;
        it.event_time     = t;
        it.event_kind     = kind;
        it.has_terminal   = ht;
        it.terminal_ref   = tr;
        it.has_record     = hr;
        it.record_ref     = rr;
        it.record_version = ver;
        return it;
    endfunction

    // Time mix: extremes, a narrow band for ties, and full range
    function automatic logic [30:0] pick_time();
        case ($urandom_range(0, 7))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2, 3:    return 31'($urandom_range(0, 15));
            4:       return 31'h7FFF_FFF0 + 31'($urandom_range(0, 15));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Present one item and hold it until the transfer; record what it owes
    task automatic push_item(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        due_results.push_back(calendar_step(it));
        items_sent++;
        if (calendar.size() > peak_fill)
            peak_fill = calendar.size();
    endtask

    // Sender in bursts: random gap with start low and junk on item between bursts
    task automatic send_item(item_t it);
        int gap;
        if (!idle_off && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            item  <= noise_item();
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        push_item(it);
    endtask

    // Extremes, every kind code, absent references, tie order, empty extracts
    task automatic test_directed();
        idle_off = 1'b1;
        send_item(extract_item());
        send_item(event_item(31'h7FFF_FFFF, 2'd2, 1'b1, 8'hFF, 1'b1, 8'hFF, 16'hFFFF));
        send_item(event_item(31'd0, 2'd3, 1'b0, 8'hFF, 1'b0, 8'hAA, 16'hFFFF));
        send_item(event_item(31'd5, 2'd0, 1'b1, 8'h01, 1'b1, 8'h10, 16'h0001));
        send_item(event_item(31'd5, 2'd1, 1'b1, 8'h02, 1'b1, 8'h20, 16'h8000));
        send_item(event_item(31'd5, 2'd2, 1'b0, 8'h03, 1'b1, 8'h30, 16'h1234));
        send_item(event_item(31'd0, 2'd0, 1'b1, 8'h00, 1'b0, 8'h00, 16'h0000));
        send_item(event_item(31'h7FFF_FFFF, 2'd1, 1'b0, 8'h00, 1'b1, 8'h00, 16'h0000));
        repeat (7) send_item(extract_item());
        send_item(extract_item());
        idle_off = 1'b0;
    endtask

    // Fill to capacity, push past it, then drain past empty; time pattern varies per round
    task automatic test_full_store();
        int          seq;
        logic [30:0] t;
        for (int round = 0; round < 4; round++)
        begin
            seq = 0;
            while (calendar.size() < DEPTH)
            begin
                case (round)
                    0:       t = pick_time();
                    1:       t = 31'(1000 + seq * 7);
                    2:       t = 31'h7FFF_FFFF - 31'(seq * 3);
                    default: t = 31'($urandom_range(0, 3));
                endcase
                send_item(schedule_item(t));
                seq++;
            end
            repeat (3) send_item(schedule_item(pick_time()));
            while (calendar.size() > 0)
                send_item(extract_item());
            repeat (2) send_item(extract_item());
        end
    endtask

    // Mixed traffic in segments, each with its own schedule bias
    task automatic test_random_mixed();
        int bias;
        for (int i = 0; i < 820; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       bias = 30;
                    1:       bias = 50;
                    2:       bias = 70;
                    default: bias = 90;
                endcase
                idle_off = ($urandom_range(0, 4) == 0);
            end
            if ($urandom_range(0, 99) < bias)
                send_item(schedule_item(pick_time()));
            else
                send_item(extract_item());
        end
        idle_off = 1'b0;
    endtask

    // Result checker: every done pulse must match the oldest owed result
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (due_results.size() == 0)
                report_mismatch("result with no transfer outstanding");
            else
            begin
                want = due_results.pop_front();
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_EMPTY)
                    empty_seen++;
                check_field("status", 32'(result.status), 32'(want.status));
                check_field("out_time", 32'(result.out_time), 32'(want.out_time));
                check_field("out_kind", 32'(result.out_kind), 32'(want.out_kind));
                check_field("out_has_terminal", 32'(result.out_has_terminal),
                            32'(want.out_has_terminal));
                check_field("out_terminal_ref", 32'(result.out_terminal_ref),
                            32'(want.out_terminal_ref));
                check_field("out_has_record", 32'(result.out_has_record),
                            32'(want.out_has_record));
                check_field("out_record_ref", 32'(result.out_record_ref),
                            32'(want.out_record_ref));
                check_field("out_record_version", 32'(result.out_record_version),
                            32'(want.out_record_version));
                check_field("next_time", 32'(result.next_time), 32'(want.next_time));
                check_field("pending_count", 32'(result.pending_count),
                            32'(want.pending_count));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_store();
        test_random_mixed();

        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers and %0d results, %0d refused as full, %0d as empty",
                 items_sent, results_seen, full_seen, empty_seen);
        $display("calendar peaked at %0d of %0d events; %0d mismatches",
                 peak_fill, DEPTH, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
